// File: rtl/core/swct_pkg.sv
// ============================================================================
// swct_pkg - scroll window cursor tracker shared definitions
// Widths, request and register codes, and small helpers shared by the
// tracker modules, the channel interfaces and the checker.
// ============================================================================
`default_nettype none

package swct_pkg;

    localparam int IDX_W   = 16;
    localparam int ROW_W   = 8;
    localparam int AMT_W   = 16;
    localparam int REQ_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W   = ((IDX_W > AMT_W) ? IDX_W : AMT_W) + 1;
    localparam int RCL_W   = ((IDX_W > ROW_W) ? IDX_W : ROW_W) + 2;

    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
    localparam logic [ROW_W-1:0] JUMP_RESET = ROW_W'(3);

    typedef enum logic [REQ_W-1:0] {
        REQ_DOWN       = 4'd0,
        REQ_UP         = 4'd1,
        REQ_JUMP_DOWN  = 4'd2,
        REQ_JUMP_UP    = 4'd3,
        REQ_HOME       = 4'd4,
        REQ_END        = 4'd5,
        REQ_INSERT     = 4'd6,
        REQ_ERASE_CUR  = 4'd7,
        REQ_ERASE_PREV = 4'd8,
        REQ_SET_SIZE   = 4'd9,
        REQ_ADD        = 4'd10,
        REQ_REMOVE     = 4'd11
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_ROWS  = 2'd0,
        CFG_LOWER_MARGIN = 2'd1,
        CFG_UPPER_MARGIN = 2'd2,
        CFG_JUMP_STEPS   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic moved;
        logic at_end;
    } t_step_flags;

    function automatic logic [ROW_W-1:0] margin_eff(
        input logic [ROW_W-1:0] m,
        input logic [ROW_W-1:0] rows
    );
        logic [ROW_W-1:0] res;
        if (m < rows) begin
            res = m;
        end else if (rows != '0) begin
            res = rows - ROW_W'(1);
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/swct_ifs.sv
// ============================================================================
// swct_ifs - tracker channel interfaces
// Request, result and register write channels, each with valid/ready.
// ============================================================================
`default_nettype none

interface swct_req_if;
    import swct_pkg::*;
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [AMT_W-1:0] amount;
    modport source (output valid, output req_type, output amount, input ready);
    modport sink   (input valid, input req_type, input amount, output ready);
endinterface

interface swct_res_if;
    import swct_pkg::*;
    logic             valid;
    logic             ready;
    logic             changed;
    logic [ROW_W-1:0] cursor_row;
    logic [IDX_W-1:0] window_offset;
    logic [IDX_W-1:0] cursor_index;
    logic             at_end;
    logic [IDX_W-1:0] list_length;
    modport source (output valid, output changed, output cursor_row, output window_offset,
                    output cursor_index, output at_end, output list_length, input ready);
    modport sink   (input valid, input changed, input cursor_row, input window_offset,
                    input cursor_index, input at_end, input list_length, output ready);
endinterface

interface swct_cfg_if;
    import swct_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ROW_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/swct_step.sv
// ============================================================================
// swct_step - single cursor step unit
// Evaluates one step up or down of cursor and window, plus the hard row
// bound and end-of-list flag of the current state.
// ============================================================================
`default_nettype none

module swct_step (
    input  wire logic                    i_dir_up,
    input  wire logic [swct_pkg::ROW_W-1:0] i_rows,
    input  wire logic [swct_pkg::ROW_W-1:0] i_lo_m,
    input  wire logic [swct_pkg::ROW_W-1:0] i_up_m,
    input  wire logic [swct_pkg::ROW_W-1:0] i_row,
    input  wire logic [swct_pkg::IDX_W-1:0] i_top,
    input  wire logic [swct_pkg::IDX_W-1:0] i_count,
    output swct_pkg::t_step_flags           o_flags,
    output logic [swct_pkg::ROW_W-1:0]      o_hb,
    output logic [swct_pkg::ROW_W-1:0]      o_row,
    output logic [swct_pkg::IDX_W-1:0]      o_top
);
    import swct_pkg::*;

    logic [IDX_W:0]   top_rows;
    logic             at_end;
    logic [ROW_W-1:0] hb;
    logic [ROW_W-1:0] me_lo;
    logic [ROW_W-1:0] me_up;
    logic             empty;

    assign top_rows = {1'b0, i_top} + (IDX_W+1)'(i_rows);
    assign at_end   = top_rows >= {1'b0, i_count};
    assign empty    = (i_rows == '0) || (i_count == '0);
    assign me_lo    = margin_eff(i_lo_m, i_rows);
    assign me_up    = margin_eff(i_up_m, i_rows);

    always_comb begin
        if (empty) begin
            hb = '0;
        end else if (IDX_W'(i_rows) > i_count) begin
            hb = ROW_W'(i_count) - ROW_W'(1);
        end else begin
            hb = i_rows - ROW_W'(1);
        end
    end

    always_comb begin
        o_row = i_row;
        o_top = i_top;
        o_flags.moved = 1'b0;
        if (i_dir_up) begin
            if (i_row <= me_lo && i_top != '0) begin
                o_top = i_top - IDX_W'(1);
                o_flags.moved = 1'b1;
            end else if (i_row != '0) begin
                o_row = i_row - ROW_W'(1);
                o_flags.moved = 1'b1;
            end
        end else if (!empty) begin
            if (i_row >= me_up && !at_end) begin
                o_top = i_top + IDX_W'(1);
                o_flags.moved = 1'b1;
            end else if (i_row < hb) begin
                o_row = i_row + ROW_W'(1);
                o_flags.moved = 1'b1;
            end
        end
    end

    assign o_flags.at_end = at_end;
    assign o_hb = hb;

endmodule

`default_nettype wire

// File: rtl/core/scroll_window_cursor_tracker_top.sv
// ============================================================================
// scroll_window_cursor_tracker_top - scroll window cursor tracker
// Keeps cursor row, window offset and list size; serves navigation and
// size requests with one step unit under a small sequencer.
// ============================================================================
//  channel  dir  payload                                          
//  i_req    in   req_type, amount                                 
//  o_res    out  changed, cursor_row, window_offset, cursor_index,
//                at_end, list_length                              
//  i_cfg    in   index, data (window_rows, margins, jump_steps)   
//
//  Moves run decode, step, output; home and end decode, output; size requests
//  decode, size, re-clamp A and B, output; insert adds a step after re-clamp,
//  a stepping erase previous one before size, jumps jump_steps steps: one step
//  unit pass per cycle. A window_rows write re-clamps with no request taken.
//  Reset clears position, size and registers (jump_steps to 3).
//  A held result does not stop the next request from being accepted.
// ============================================================================
`default_nettype none

module scroll_window_cursor_tracker_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    swct_req_if.sink   i_req,
    swct_cfg_if.sink   i_cfg,
    swct_res_if.source o_res
);
    import swct_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STEP,
        ST_SIZE,
        ST_RCL_A,
        ST_RCL_B,
        ST_OUT
    } t_state;

    t_state           r_state;
    t_req             r_op;
    logic [AMT_W-1:0] r_amt;
    logic             r_chg;
    logic [ROW_W-1:0] r_left;
    logic             r_cfgop;
    logic [ROW_W-1:0] r_rows;
    logic [ROW_W-1:0] r_lo;
    logic [ROW_W-1:0] r_up;
    logic [ROW_W-1:0] r_jump;
    logic [ROW_W-1:0] r_row;
    logic [IDX_W-1:0] r_top;
    logic [IDX_W-1:0] r_count;
    logic [RCL_W-1:0] r_rowx;

    logic             r_ov;
    logic             r_o_chg;
    logic [ROW_W-1:0] r_o_row;
    logic [IDX_W-1:0] r_o_top;
    logic [IDX_W-1:0] r_o_idx;
    logic             r_o_end;
    logic [IDX_W-1:0] r_o_len;

    t_step_flags      s_flags;
    logic [ROW_W-1:0] s_hb;
    logic [ROW_W-1:0] s_row;
    logic [IDX_W-1:0] s_top;
    logic             dir_up;

    logic             req_acc;
    logic             cfg_acc;
    logic             out_free;
    logic             count_gt_rows;
    logic [IDX_W-1:0] end_top;

    logic [SUM_W-1:0] sz_a;
    logic [SUM_W-1:0] sz_b;
    logic [SUM_W-1:0] sz_s;
    logic [IDX_W-1:0] sz_new;

    logic [RCL_W-1:0] rc_top_rows;
    logic [RCL_W-1:0] rc_cnt;
    logic             rc_hit;

    assign req_acc  = i_req.valid && i_req.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_ov || o_res.ready;

    assign i_cfg.ready = (r_state == ST_IDLE);
    assign i_req.ready = (r_state == ST_IDLE) && !i_cfg.valid;

    assign count_gt_rows = r_count > IDX_W'(r_rows);
    assign end_top       = count_gt_rows ? (r_count - IDX_W'(r_rows)) : '0;

    always_comb begin
        dir_up = r_op inside {REQ_UP, REQ_JUMP_UP, REQ_ERASE_PREV};
    end

    swct_step u_step (
        .i_dir_up (dir_up),
        .i_rows   (r_rows),
        .i_lo_m   (r_lo),
        .i_up_m   (r_up),
        .i_row    (r_row),
        .i_top    (r_top),
        .i_count  (r_count),
        .o_flags  (s_flags),
        .o_hb     (s_hb),
        .o_row    (s_row),
        .o_top    (s_top)
    );

    always_comb begin
        sz_a = SUM_W'(r_count);
        case (r_op)
            REQ_INSERT, REQ_ERASE_CUR, REQ_ERASE_PREV: sz_b = SUM_W'(1);
            default:                                   sz_b = SUM_W'(r_amt);
        endcase
        case (r_op)
            REQ_INSERT, REQ_ADD: sz_s = sz_a + sz_b;
            REQ_SET_SIZE:        sz_s = sz_b;
            default:             sz_s = (sz_a >= sz_b) ? (sz_a - sz_b) : '0;
        endcase
        sz_new = (sz_s > SUM_W'(IDX_MAX)) ? IDX_MAX : sz_s[IDX_W-1:0];
    end

    assign rc_top_rows = RCL_W'(r_top) + RCL_W'(r_rows);
    assign rc_cnt      = RCL_W'(r_count);
    assign rc_hit      = (r_top != '0) && (rc_top_rows > rc_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cfgop <= 1'b0;
            r_rows  <= '0;
            r_lo    <= '0;
            r_up    <= '0;
            r_jump  <= JUMP_RESET;
            r_row   <= '0;
            r_top   <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == ST_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (cfg_acc) begin
                        case (t_cfg_reg'(i_cfg.index))
                            CFG_WINDOW_ROWS: begin
                                r_rows  <= i_cfg.data;
                                r_cfgop <= 1'b1;
                                r_state <= ST_RCL_A;
                            end
                            CFG_LOWER_MARGIN: r_lo <= i_cfg.data;
                            CFG_UPPER_MARGIN: r_up <= i_cfg.data;
                            CFG_JUMP_STEPS:
                                r_jump <= (i_cfg.data != '0) ? i_cfg.data : ROW_W'(1);
                            default: ;
                        endcase
                    end else if (req_acc) begin
                        r_op    <= t_req'(i_req.req_type);
                        r_amt   <= i_req.amount;
                        r_cfgop <= 1'b0;
                        r_state <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    case (r_op)
                        REQ_DOWN, REQ_UP: begin
                            r_chg   <= 1'b0;
                            r_left  <= ROW_W'(1);
                            r_state <= ST_STEP;
                        end
                        REQ_JUMP_DOWN, REQ_JUMP_UP: begin
                            r_chg   <= 1'b0;
                            r_left  <= r_jump;
                            r_state <= ST_STEP;
                        end
                        REQ_HOME: begin
                            r_chg   <= (r_row != '0) || (r_top != '0);
                            r_row   <= '0;
                            r_top   <= '0;
                            r_state <= ST_OUT;
                        end
                        REQ_END: begin
                            if (r_rows != '0 && r_count != '0) begin
                                r_chg <= (r_row != s_hb) || !s_flags.at_end;
                                r_row <= s_hb;
                                r_top <= end_top;
                            end else begin
                                r_chg <= 1'b0;
                            end
                            r_state <= ST_OUT;
                        end
                        REQ_INSERT, REQ_SET_SIZE, REQ_ADD, REQ_REMOVE: begin
                            r_chg   <= 1'b1;
                            r_left  <= ROW_W'(1);
                            r_state <= ST_SIZE;
                        end
                        REQ_ERASE_CUR: begin
                            if (r_count == '0) begin
                                r_chg   <= 1'b0;
                                r_state <= ST_OUT;
                            end else begin
                                if (s_flags.at_end && count_gt_rows) begin
                                    if (r_top != '0) begin
                                        r_top <= r_top - IDX_W'(1);
                                    end
                                    if (r_rows != '0 && r_row < s_hb) begin
                                        r_row <= r_row + ROW_W'(1);
                                    end
                                end
                                r_chg   <= 1'b1;
                                r_state <= ST_SIZE;
                            end
                        end
                        REQ_ERASE_PREV: begin
                            if (r_top == '0 && r_row == '0) begin
                                r_chg   <= 1'b0;
                                r_state <= ST_OUT;
                            end else if (s_flags.at_end && count_gt_rows) begin
                                if (r_top != '0) begin
                                    r_top <= r_top - IDX_W'(1);
                                end
                                r_chg   <= 1'b1;
                                r_state <= ST_SIZE;
                            end else begin
                                r_chg   <= 1'b1;
                                r_left  <= ROW_W'(1);
                                r_state <= ST_STEP;
                            end
                        end
                        default: begin
                            r_chg   <= 1'b0;
                            r_state <= ST_OUT;
                        end
                    endcase
                end
                ST_STEP: begin
                    r_row  <= s_row;
                    r_top  <= s_top;
                    r_chg  <= r_chg || s_flags.moved;
                    r_left <= r_left - ROW_W'(1);
                    if (r_left <= ROW_W'(1)) begin
                        r_state <= (r_op == REQ_ERASE_PREV) ? ST_SIZE : ST_OUT;
                    end
                end
                ST_SIZE: begin
                    r_count <= sz_new;
                    r_state <= ST_RCL_A;
                end
                ST_RCL_A: begin
                    if (rc_hit) begin
                        r_rowx <= RCL_W'(r_row) + rc_top_rows - rc_cnt;
                        r_top  <= end_top;
                    end else begin
                        r_rowx <= RCL_W'(r_row);
                    end
                    r_state <= ST_RCL_B;
                end
                ST_RCL_B: begin
                    r_row <= (r_rowx > RCL_W'(s_hb)) ? s_hb : r_rowx[ROW_W-1:0];
                    if (r_cfgop) begin
                        r_state <= ST_IDLE;
                    end else if (r_op == REQ_INSERT) begin
                        r_state <= ST_STEP;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_o_chg <= r_chg;
                        r_o_row <= r_row;
                        r_o_top <= r_top;
                        r_o_idx <= r_top + IDX_W'(r_row);
                        r_o_end <= s_flags.at_end;
                        r_o_len <= r_count;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.changed       = r_o_chg;
    assign o_res.cursor_row    = r_o_row;
    assign o_res.window_offset = r_o_top;
    assign o_res.cursor_index  = r_o_idx;
    assign o_res.at_end        = r_o_end;
    assign o_res.list_length   = r_o_len;

endmodule

`default_nettype wire

// File: rtl/core/swct_chk.sv
// ============================================================================
// swct_chk - tracker port checker
// Watches tracker ports for broken sequencing and a wrong cursor index sum.
// ============================================================================
`default_nettype none

module swct_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_req_valid,
    input wire logic                           i_req_ready,
    input wire logic                           i_cfg_valid,
    input wire logic                           i_cfg_ready,
    input wire logic [swct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input wire logic                           i_res_valid,
    input wire logic                           i_res_ready,
    input wire logic [swct_pkg::ROW_W-1:0]     i_res_row,
    input wire logic [swct_pkg::IDX_W-1:0]     i_res_offset,
    input wire logic [swct_pkg::IDX_W-1:0]     i_res_index
);
    import swct_pkg::*;

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req_valid && i_req_ready && i_cfg_valid && i_cfg_ready))
        else $error("request and register beats on the same edge");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while previous beat still in work");

    a_busy_after_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_ready && i_cfg_index == CFG_WINDOW_ROWS) |=> !i_req_ready)
        else $error("request taken during window re-clamp");

    a_index_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_index == (i_res_offset + IDX_W'(i_res_row))))
        else $error("cursor index differs from offset plus row");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_index)))
        else $error("stalled result beat dropped or changed");

endmodule

bind scroll_window_cursor_tracker_top swct_chk u_swct_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_cfg_valid  (i_cfg.valid),
    .i_cfg_ready  (i_cfg.ready),
    .i_cfg_index  (i_cfg.index),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_row    (o_res.cursor_row),
    .i_res_offset (o_res.window_offset),
    .i_res_index  (o_res.cursor_index)
);

`default_nettype wire
